// ----- src/eiwa_pkg.sv -----
// eiwa_pkg: sizes, types and state codes for the event interval window average block
// depends on nothing; imported by every module of the block
`default_nettype none

package eiwa_pkg;

    localparam int CHANNELS = 64;
    localparam int WINDOW   = 20;

    // fixed field widths
    localparam int CH_W       = 6;
    localparam int LEVEL_W    = 16;
    localparam int FILL_OUT_W = 5;

    localparam logic [LEVEL_W-1:0] COUNT_MAX = '1;

    // derived sizes
    localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HEAD_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int POS_W      = FILL_W + 1;
    localparam int SUM_W      = $clog2(WINDOW * (2 ** LEVEL_W - 1) + 1);
    localparam int HIST_DEPTH = CHANNELS * WINDOW;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int RCP_W      = SUM_W + 1;
    localparam int PROD_W     = SUM_W + RCP_W;

    typedef logic [CH_AW-1:0] t_ch_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] count;
        logic [LEVEL_W-1:0] prior;
        logic [HEAD_W-1:0]  head;
        logic [FILL_W-1:0]  fill;
        logic [SUM_W-1:0]   sum;
    } t_chan_ent;

    typedef struct packed {
        logic               valid;
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] interval;
        logic [SUM_W-1:0]   sum;
        logic [FILL_W-1:0]  fill;
    } t_div_req;

    typedef enum logic [1:0] {
        UPD_IDLE,
        UPD_CHAN,
        UPD_WRITE
    } t_upd_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_FIX
    } t_div_state;

endpackage

`default_nettype wire

// ----- src/event_interval_window_average_top.sv -----
// event_interval_window_average_top: top level of the per-channel interval averager
// depends on eiwa_pkg, eiwa_update and eiwa_div
//
// Each input beat carries one channel's level for one frame. The block keeps, per channel,
// the stored level, a saturating frame counter, the last interval and a circular window of
// the last WINDOW intervals, all in two single-port synchronous memories, and answers every
// beat with the channel, its last interval, the truncated window mean and the window fill.
// An item passes through the update states in order (accept and channel-memory read, history
// read, write-back), and no new item is taken before the last one is written back; the
// mean is then formed by a reciprocal multiply and one correction step, which overlaps
// the next item's update. A held result stalls the block only once a second one is
// ready behind it. Channel indexes at or above CHANNELS are taken and dropped with no result.
// No clearing pass is needed after reset: a per-channel seen bit marks unwritten entries.
`default_nettype none

module event_interval_window_average_top
    import eiwa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [CH_W-1:0]       i_channel,
    input  wire logic [LEVEL_W-1:0]    i_level,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [CH_W-1:0]            o_channel_out,
    output logic [LEVEL_W-1:0]         o_last_interval,
    output logic [LEVEL_W-1:0]         o_window_average,
    output logic [FILL_OUT_W-1:0]      o_window_fill
);

    t_div_req w_req;
    logic     w_div_ready;

    eiwa_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_channel   (i_channel),
        .i_level     (i_level),
        .i_div_ready (w_div_ready),
        .o_req       (w_req)
    );

    eiwa_div u_div (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (w_req),
        .o_div_ready      (w_div_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_channel_out    (o_channel_out),
        .o_last_interval  (o_last_interval),
        .o_window_average (o_window_average),
        .o_window_fill    (o_window_fill)
    );

endmodule

`default_nettype wire

// ----- src/eiwa_update.sv -----
// eiwa_update: per-channel read-modify-write of channel state and interval history
// depends on eiwa_pkg; hands window sum and fill to eiwa_div
`default_nettype none

module eiwa_update
    import eiwa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [CH_W-1:0]    i_channel,
    input  wire logic [LEVEL_W-1:0] i_level,
    input  wire logic               i_div_ready,
    output t_div_req                o_req
);

    t_upd_state r_state, n_state;

    logic [CH_W-1:0]    r_channel;
    logic [LEVEL_W-1:0] r_level;
    logic [CHANNELS-1:0] r_seen;

    t_chan_ent          r_chan_mem [CHANNELS];
    t_chan_ent          r_chan_rd;
    logic [LEVEL_W-1:0] r_hist_mem [HIST_DEPTH];
    logic [LEVEL_W-1:0] r_hist_rd;

    logic               w_accept;
    logic               w_in_range;
    logic               w_write;
    t_ch_idx            w_idx;
    logic [HIST_AW-1:0] w_base;
    logic [HIST_AW-1:0] w_hist_raddr;
    logic [HIST_AW-1:0] w_hist_waddr;
    logic               w_hist_we;
    logic [HEAD_W-1:0]  w_slot;
    logic [POS_W-1:0]   w_pos;
    logic [POS_W-1:0]   w_head_inc;
    logic               w_first;
    logic               w_changed;
    t_chan_ent          w_new_ent;

    assign o_ready    = (r_state == UPD_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_in_range = (int'(i_channel) < CHANNELS);
    assign w_write    = (r_state == UPD_WRITE) && i_div_ready;
    assign w_idx      = t_ch_idx'(r_channel);
    assign w_base     = HIST_AW'(w_idx) * HIST_AW'(WINDOW);

    // oldest entry of the window, needed only when the window is full
    assign w_hist_raddr = w_base + HIST_AW'(r_chan_rd.head);
    assign w_hist_waddr = w_base + HIST_AW'(w_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= UPD_IDLE;
            r_seen  <= '0;
        end else begin
            r_state <= n_state;
            if (w_write) begin
                r_seen[w_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_channel <= i_channel;
            r_level   <= i_level;
        end
    end

    // channel state memory: read on the accept beat, written back once per item
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_chan_mem[w_idx] <= w_new_ent;
        end
        if (w_accept && w_in_range) begin
            r_chan_rd <= r_chan_mem[t_ch_idx'(i_channel)];
        end
    end

    // history memory: read in the cycle after the channel read, written with the state
    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            r_hist_mem[w_hist_waddr] <= r_chan_rd.count;
        end
        if (r_state == UPD_CHAN) begin
            r_hist_rd <= r_hist_mem[w_hist_raddr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            UPD_IDLE: begin
                if (w_accept && w_in_range) begin
                    n_state = UPD_CHAN;
                end
            end
            UPD_CHAN: begin
                n_state = UPD_WRITE;
            end
            UPD_WRITE: begin
                if (i_div_ready) begin
                    n_state = UPD_IDLE;
                end
            end
            default: begin
                n_state = UPD_IDLE;
            end
        endcase
    end

    always_comb begin
        w_first    = !r_seen[w_idx];
        w_changed  = (r_level != r_chan_rd.level);
        w_new_ent  = r_chan_rd;
        w_hist_we  = 1'b0;
        w_slot     = r_chan_rd.head;

        // slot after the newest entry, and the head advanced by one, both mod window
        w_pos = POS_W'(r_chan_rd.head) + POS_W'(r_chan_rd.fill);
        if (w_pos >= POS_W'(WINDOW)) begin
            w_pos = w_pos - POS_W'(WINDOW);
        end
        w_head_inc = POS_W'(r_chan_rd.head) + POS_W'(1);
        if (w_head_inc >= POS_W'(WINDOW)) begin
            w_head_inc = w_head_inc - POS_W'(WINDOW);
        end

        if (w_first) begin
            w_new_ent.level = r_level;
            w_new_ent.count = '0;
            w_new_ent.prior = '0;
            w_new_ent.head  = '0;
            w_new_ent.fill  = '0;
            w_new_ent.sum   = '0;
        end else if (w_changed) begin
            w_new_ent.prior = r_chan_rd.count;
            w_new_ent.level = r_level;
            w_new_ent.count = '0;
            w_hist_we       = w_write;
            if (int'(r_chan_rd.fill) < WINDOW) begin
                w_slot         = HEAD_W'(w_pos);
                w_new_ent.fill = r_chan_rd.fill + FILL_W'(1);
                w_new_ent.sum  = r_chan_rd.sum + SUM_W'(r_chan_rd.count);
            end else begin
                // full window: overwrite the oldest entry
                w_slot         = r_chan_rd.head;
                w_new_ent.head = HEAD_W'(w_head_inc);
                w_new_ent.sum  = r_chan_rd.sum - SUM_W'(r_hist_rd)
                                 + SUM_W'(r_chan_rd.count);
            end
        end else if (r_chan_rd.count != COUNT_MAX) begin
            w_new_ent.count = r_chan_rd.count + LEVEL_W'(1);
        end
    end

    assign o_req.valid    = w_write;
    assign o_req.ch       = r_channel;
    assign o_req.interval = w_new_ent.prior;
    assign o_req.sum      = w_new_ent.sum;
    assign o_req.fill     = w_new_ent.fill;

endmodule

`default_nettype wire

// ----- src/eiwa_div.sv -----
// eiwa_div: window mean by reciprocal multiply with one correction step, and result register
// depends on eiwa_pkg; fed by eiwa_update
`default_nettype none

module eiwa_div
    import eiwa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_div_req              i_req,
    output logic                       o_div_ready,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [CH_W-1:0]            o_channel_out,
    output logic [LEVEL_W-1:0]         o_last_interval,
    output logic [LEVEL_W-1:0]         o_window_average,
    output logic [FILL_OUT_W-1:0]      o_window_fill
);

    t_div_state r_state, n_state;

    logic [CH_W-1:0]    r_ch;
    logic [LEVEL_W-1:0] r_interval;
    logic [SUM_W-1:0]   r_num;
    logic [FILL_W-1:0]  r_fill;
    logic [PROD_W-1:0]  r_prod;

    logic                  r_out_valid;
    logic [CH_W-1:0]       r_out_ch;
    logic [LEVEL_W-1:0]    r_out_interval;
    logic [LEVEL_W-1:0]    r_out_avg;
    logic [FILL_OUT_W-1:0] r_out_fill;

    logic [RCP_W-1:0]           w_recip [WINDOW+1];
    logic                       w_out_free;
    logic                       w_load;
    logic [LEVEL_W-1:0]         w_q_est;
    logic [LEVEL_W+FILL_W-1:0]  w_qf;
    logic [SUM_W:0]             w_rem;
    logic [LEVEL_W-1:0]         w_avg;

    // floor(2^SUM_W / f): the estimate is the true quotient or one below it
    for (genvar g = 0; g <= WINDOW; g++) begin : g_rcp
        localparam longint unsigned Rcp = (longint'(2) ** SUM_W) / ((g == 0) ? 1 : g);
        assign w_recip[g] = (g == 0) ? '0 : RCP_W'(Rcp);
    end

    assign o_div_ready = (r_state == DIV_IDLE);
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_load      = (r_state == DIV_FIX) && w_out_free;

    assign w_q_est = r_prod[SUM_W +: LEVEL_W];
    assign w_qf    = (LEVEL_W + FILL_W)'(w_q_est) * (LEVEL_W + FILL_W)'(r_fill);
    assign w_rem   = (SUM_W + 1)'(r_num) - (SUM_W + 1)'(w_qf);

    always_comb begin
        if (r_fill == '0) begin
            w_avg = '0;
        end else if (w_rem >= (SUM_W + 1)'(r_fill)) begin
            w_avg = w_q_est + LEVEL_W'(1);
        end else begin
            w_avg = w_q_est;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: begin
                if (i_req.valid) begin
                    n_state = DIV_MUL;
                end
            end
            DIV_MUL: begin
                n_state = DIV_FIX;
            end
            DIV_FIX: begin
                if (w_out_free) begin
                    n_state = DIV_IDLE;
                end
            end
            default: begin
                n_state = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DIV_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == DIV_IDLE) && i_req.valid) begin
            r_ch       <= i_req.ch;
            r_interval <= i_req.interval;
            r_num      <= i_req.sum;
            r_fill     <= i_req.fill;
        end
        if (r_state == DIV_MUL) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(w_recip[r_fill]);
        end
        if (w_load) begin
            r_out_ch       <= r_ch;
            r_out_interval <= r_interval;
            r_out_avg      <= w_avg;
            r_out_fill     <= FILL_OUT_W'(r_fill);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_channel_out    = r_out_ch;
    assign o_last_interval  = r_out_interval;
    assign o_window_average = r_out_avg;
    assign o_window_fill    = r_out_fill;

endmodule

`default_nettype wire

// ----- src/eiwa_checker.sv -----
// eiwa_checker: port-level assertions for the interval averager, bound to the top level
// depends on eiwa_pkg
`default_nettype none

module eiwa_checker
    import eiwa_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic [CH_W-1:0]       o_channel_out,
    input wire logic [LEVEL_W-1:0]    o_last_interval,
    input wire logic [LEVEL_W-1:0]    o_window_average,
    input wire logic [FILL_OUT_W-1:0] o_window_fill
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_channel_out)
            && $stable(o_last_interval) && $stable(o_window_average)
            && $stable(o_window_fill))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> int'(o_window_fill) <= WINDOW)
        else $error("window fill above window size");

    // empty window: nothing pushed yet, so no interval either
    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_window_fill == '0) |-> (o_window_average == '0)
            && (o_last_interval == '0))
        else $error("empty window with nonzero mean or interval");

    // one entry held: it is the interval just pushed
    a_single_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_window_fill == FILL_OUT_W'(1)) |-> o_window_average == o_last_interval)
        else $error("single-entry window mean differs from last interval");

endmodule

bind event_interval_window_average_top eiwa_checker u_eiwa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_channel_out    (o_channel_out),
    .o_last_interval  (o_last_interval),
    .o_window_average (o_window_average),
    .o_window_fill    (o_window_fill)
);

`default_nettype wire

// ----- tb/eiwa_interval_checker.sv -----
`timescale 1ns / 100ps
// eiwa_interval_checker: watches the input and output handshakes of the interval averager,
// predicts each result and compares it field by field; depends on eiwa_pkg only

module eiwa_interval_checker
    import eiwa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [LEVEL_W-1:0]    i_level,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [CH_W-1:0]       i_channel_out,
    input  logic [LEVEL_W-1:0]    i_last_interval,
    input  logic [LEVEL_W-1:0]    i_window_average,
    input  logic [FILL_OUT_W-1:0] i_window_fill,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [CH_W-1:0]       channel;
        logic [LEVEL_W-1:0]    last_interval;
        logic [LEVEL_W-1:0]    average;
        logic [FILL_OUT_W-1:0] fill;
    } t_interval_report;

    // per-channel copy of the block state
    logic               chan_seen  [CHANNELS];
    logic [LEVEL_W-1:0] chan_level [CHANNELS];
    logic [LEVEL_W-1:0] chan_count [CHANNELS];
    logic [LEVEL_W-1:0] chan_prior [CHANNELS];
    logic [LEVEL_W-1:0] chan_hist  [CHANNELS][WINDOW];
    logic [HEAD_W-1:0]  chan_head  [CHANNELS];
    logic [FILL_W-1:0]  chan_fill  [CHANNELS];
    logic [SUM_W-1:0]   chan_sum   [CHANNELS];

    t_interval_report expected_reports [$];
    int               bad_results;

    function automatic t_interval_report observe_level(input logic [CH_W-1:0] ch,
                                                       input logic [LEVEL_W-1:0] lvl);
        t_interval_report rep;
        int               slot;
        logic [SUM_W-1:0] mean;
        if (!chan_seen[ch]) begin
            chan_seen[ch]  = 1'b1;
            chan_level[ch] = lvl;
            chan_count[ch] = '0;
            chan_prior[ch] = '0;
            chan_head[ch]  = '0;
            chan_fill[ch]  = '0;
            chan_sum[ch]   = '0;
        end else if (lvl != chan_level[ch]) begin
            chan_prior[ch] = chan_count[ch];
            chan_level[ch] = lvl;
            chan_count[ch] = '0;
            if (int'(chan_fill[ch]) < WINDOW) begin
                slot = (int'(chan_head[ch]) + int'(chan_fill[ch])) % WINDOW;
                chan_hist[ch][slot] = chan_prior[ch];
                chan_fill[ch] = chan_fill[ch] + FILL_W'(1);
                chan_sum[ch]  = chan_sum[ch] + SUM_W'(chan_prior[ch]);
            end else begin
                // full window: oldest interval drops out
                slot = int'(chan_head[ch]);
                chan_sum[ch] = chan_sum[ch] - SUM_W'(chan_hist[ch][slot])
                               + SUM_W'(chan_prior[ch]);
                chan_hist[ch][slot] = chan_prior[ch];
                chan_head[ch] = HEAD_W'((slot + 1) % WINDOW);
            end
        end else if (chan_count[ch] != COUNT_MAX) begin
            chan_count[ch] = chan_count[ch] + LEVEL_W'(1);
        end
        mean = (chan_fill[ch] != '0) ? chan_sum[ch] / SUM_W'(chan_fill[ch]) : '0;
        rep.channel       = ch;
        rep.last_interval = chan_prior[ch];
        rep.average       = mean[LEVEL_W-1:0];
        rep.fill          = FILL_OUT_W'(chan_fill[ch]);
        return rep;
    endfunction

    function automatic void store_expected(input t_interval_report rep);
        expected_reports = {expected_reports, rep};
    endfunction

    always @(posedge i_clk) begin
        t_interval_report want;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) chan_seen[c] = 1'b0;
            expected_reports.delete();
            bad_results = 0;
        end else begin
            // drain side first: a result never belongs to the beat taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: unexpected result ch %0d interval %0d avg %0d fill %0d",
                                 $time, i_channel_out, i_last_interval, i_window_average,
                                 i_window_fill);
                end else begin
                    want = expected_reports.pop_front();
                    if (want.channel !== i_channel_out || want.last_interval !== i_last_interval
                        || want.average !== i_window_average || want.fill !== i_window_fill) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display({"%0t: mismatch, expected ch %0d interval %0d avg %0d ",
                                      "fill %0d, got ch %0d interval %0d avg %0d fill %0d"},
                                     $time, want.channel, want.last_interval, want.average,
                                     want.fill, i_channel_out, i_last_interval,
                                     i_window_average, i_window_fill);
                    end
                end
            end
            if (i_in_valid && i_in_ready && int'(i_channel) < CHANNELS)
                store_expected(observe_level(i_channel, i_level));
        end
        o_errors  <= bad_results;
        o_pending <= expected_reports.size();
    end

endmodule

// ----- tb/event_interval_window_average_top_tb.sv -----
`timescale 1ns / 100ps
// event_interval_window_average_top_tb: stimulus, back-pressure and verdict for the averager
// depends on eiwa_pkg, event_interval_window_average_top and eiwa_interval_checker

module event_interval_window_average_top_tb;
    import eiwa_pkg::*;

    localparam int N_DIRECTED   = 14;
    localparam int N_CHUNKS     = 9;
    localparam int CHUNK_ITEMS  = 48;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [CH_W-1:0]       i_channel;
    logic [LEVEL_W-1:0]    i_level;
    logic                  o_valid;
    logic                  i_ready;
    logic [CH_W-1:0]       o_channel_out;
    logic [LEVEL_W-1:0]    o_last_interval;
    logic [LEVEL_W-1:0]    o_window_average;
    logic [FILL_OUT_W-1:0] o_window_fill;

    int   mismatch_count;
    int   pending_results;
    logic rx_stalls = 1'b0;
    logic hold_req  = 1'b0;
    int   quiet_cycles = 0;

    // first beat of a channel, repeats, changes at both level extremes, immediate change
    logic [CH_W-1:0]    dir_ch  [N_DIRECTED] = '{0, 0, 0, 0, 0, 0, 0, 63, 63, 42, 21, 42, 21, 63};
    logic [LEVEL_W-1:0] dir_lvl [N_DIRECTED] = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                                                 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF,
                                                 16'h0000, 16'hAAAA, 16'h5555, 16'h5555,
                                                 16'hAAAA, 16'h0000};

    logic [LEVEL_W-1:0] last_level [CHANNELS];
    logic [CH_W-1:0]    hot_ch     [4];

    event_interval_window_average_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_channel        (i_channel),
        .i_level          (i_level),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_channel_out    (o_channel_out),
        .o_last_interval  (o_last_interval),
        .o_window_average (o_window_average),
        .o_window_fill    (o_window_fill)
    );

    eiwa_interval_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_channel        (i_channel),
        .i_level          (i_level),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_channel_out    (o_channel_out),
        .i_last_interval  (o_last_interval),
        .i_window_average (o_window_average),
        .i_window_fill    (o_window_fill),
        .o_errors         (mismatch_count),
        .o_pending        (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer_level(input logic [CH_W-1:0] ch, input logic [LEVEL_W-1:0] lvl,
                               input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_channel <= ch;
        i_level   <= lvl;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    task automatic offer_random_level(input logic sender_gaps);
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] lvl;
        int                 p;
        if ($urandom_range(0, 99) < 85) ch = hot_ch[$urandom_range(0, 3)];
        else ch = CH_W'($urandom_range(0, CHANNELS - 1));
        p = $urandom_range(0, 99);
        if (p < 58) lvl = last_level[ch];
        else if (p < 65) lvl = '0;
        else if (p < 72) lvl = '1;
        else lvl = LEVEL_W'($urandom());
        last_level[ch] = lvl;
        offer_level(ch, lvl, sender_gaps ? idle_cycles() : 0);
    endtask

    // receiver: random stalls when enabled, one long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = rx_stalls ? idle_cycles() : 0;
                if (n > 0) begin
                    i_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end else begin
                    i_ready <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    // watchdog: too long without any beat on either side
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_channel <= '0;
        i_level   <= '0;
        for (int c = 0; c < CHANNELS; c++) last_level[c] = '0;
        for (int h = 0; h < 4; h++) hot_ch[h] = CH_W'($urandom_range(0, CHANNELS - 1));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) offer_level(dir_ch[k], dir_lvl[k], 0);

        for (int chunk = 0; chunk < N_CHUNKS; chunk++) begin
            // cycle through no idling, sender gaps, receiver stalls, both
            rx_stalls = (chunk % 4 == 2) || (chunk % 4 == 3);
            for (int k = 0; k < CHUNK_ITEMS; k++)
                offer_random_level((chunk % 4 == 1) || (chunk % 4 == 3));
            if (chunk == 2) begin
                // long hold-off on the result side while beats keep coming
                rx_stalls = 1'b0;
                hold_req  = 1'b1;
                for (int k = 0; k < 40; k++) offer_random_level(1'b0);
            end
            if (chunk == 5) wait_results_drained();
        end

        rx_stalls = 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
